// ===== hw/rtl/fed_pkg.sv =====
// Package for the feedback echo delay line: sample, delay and address widths,
// register map and saturation limits. No dependencies.
package fed_pkg;

  localparam int unsigned MAX_DELAY  = 16384;
  localparam int unsigned MEM_ADDR_W = $clog2(MAX_DELAY);
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned DELAY_W    = 14;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 14'd13230;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // Register word index (byte address / 4)
  typedef enum logic [0:0] {
    REG_DELAY = 1'b0
  } reg_idx_e;

endpackage

// ===== hw/rtl/fed_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; used for the echo sample store.
module fed_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/feedback_echo_delay_line.sv =====
// Feedback echo delay line: y = sat16((2x + y[n-D]) / 2), truncated toward zero,
// inside a frame. Depends on fed_pkg and fed_ram.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries sample_in_i and
//   frame_start_i; output channel (out_valid_o/out_ready_i) carries
//   sample_out_o. One result per input transfer, in order.
//   A sample passes the stage 1 register and then the output register,
//   which drives out_valid_o. Throughput is one sample per cycle while
//   out_ready_i keeps the output moving; the echo store is one 16384 x 16
//   RAM with one write and one registered read port, and each sample uses
//   one read at accept and one write when it leaves the compute stage. A
//   delay of one sample is served by forwarding the result being written
//   straight into the next sample.
//   The APB port holds delay_samples at byte address 0; a delay of 0 turns
//   the echo off. Write it only while the block is idle.
//   Reset sets the delay to 13230, the write pointer and frame position to
//   zero; the sample store is not cleared (its read data is used only where
//   the same frame has written it). When out_valid_o is high and out_ready_i
//   is low the output register holds, one more sample can still be taken into
//   the compute stage, and then in_ready_o drops until the output is drained.
module feedback_echo_delay_line
  import fed_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [SAMPLE_W-1:0]   sample_in_i,
  input  logic                         frame_start_i,
  // Output channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [SAMPLE_W-1:0]   sample_out_o,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_W-1:0]        paddr,
  input  logic [APB_DATA_W-1:0]        pwdata,
  output logic [APB_DATA_W-1:0]        prdata,
  output logic                         pready
);

  // Configuration register
  logic [DELAY_W-1:0] delay_q;
  logic               cfg_wr;
  logic               sel_delay;

  assign pready    = 1'b1;
  assign sel_delay = (reg_idx_e'(paddr[2]) == REG_DELAY);
  assign cfg_wr    = psel && penable && pwrite && sel_delay;
  assign prdata    = sel_delay ? {{(APB_DATA_W-DELAY_W){1'b0}}, delay_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_RESET;
    end else if (cfg_wr) begin
      delay_q <= pwdata[DELAY_W-1:0];
    end
  end

  // Pipeline control
  logic s1_v_q, out_v_q;
  logic s1_adv, accept;

  assign s1_adv     = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  // Stage 0: frame position, echo decision, tap address
  logic [MEM_ADDR_W-1:0] wp_q;
  logic [DELAY_W-1:0]    fp_q;
  logic [DELAY_W-1:0]    fp_eff;
  logic                  echo_en;
  logic [MEM_ADDR_W-1:0] rd_addr;
  logic                  fwd_hit;
  logic [MEM_ADDR_W-1:0] s1_wp_q;

  assign fp_eff  = frame_start_i ? '0 : fp_q;
  assign echo_en = (delay_q != '0) && (fp_eff >= delay_q);
  assign rd_addr = wp_q - MEM_ADDR_W'(delay_q);
  // tap is being written by the sample in stage 1 at this same edge
  assign fwd_hit = s1_adv && (s1_wp_q == rd_addr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      fp_q <= '0;
    end else if (accept) begin
      wp_q <= wp_q + 1'b1;
      fp_q <= (fp_eff < delay_q) ? fp_eff + 1'b1 : fp_eff;
    end
  end

  // Stage 1 registers
  logic signed [SAMPLE_W-1:0] s1_x_q;
  logic                       s1_echo_q;
  logic                       s1_fwd_q;
  logic signed [SAMPLE_W-1:0] s1_fwd_data_q;

  // Stage 1: echo arithmetic
  logic signed [SAMPLE_W-1:0] ram_rdata;
  logic signed [SAMPLE_W-1:0] past;
  logic signed [SAMPLE_W+1:0] sum2;
  logic signed [SAMPLE_W+1:0] sum2_adj;
  logic signed [SAMPLE_W:0]   sum;
  logic signed [SAMPLE_W-1:0] sum_sat;
  logic signed [SAMPLE_W-1:0] y;

  assign past     = s1_fwd_q ? s1_fwd_data_q : ram_rdata;
  // 2x + past, then halve truncating toward zero: add one before the shift
  // when the sum is negative
  assign sum2     = {s1_x_q[SAMPLE_W-1], s1_x_q, 1'b0}
                  + {{2{past[SAMPLE_W-1]}}, past};
  assign sum2_adj = sum2 + {{(SAMPLE_W+1){1'b0}}, sum2[SAMPLE_W+1]};
  assign sum      = sum2_adj[SAMPLE_W+1:1];

  always_comb begin
    if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
      sum_sat = sum[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      sum_sat = sum[SAMPLE_W-1:0];
    end
  end

  assign y = s1_echo_q ? sum_sat : s1_x_q;

  // Stage 1 and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers
  logic signed [SAMPLE_W-1:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q        <= sample_in_i;
      s1_echo_q     <= echo_en;
      s1_fwd_q      <= fwd_hit;
      s1_fwd_data_q <= y;
      s1_wp_q       <= wp_q;
    end
    if (s1_adv) begin
      out_data_q <= y;
    end
  end

  assign out_valid_o  = out_v_q;
  assign sample_out_o = out_data_q;

  // Echo sample store
  logic [SAMPLE_W-1:0] ram_rdata_raw;

  fed_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_DELAY)
  ) u_echo_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_wp_q),
    .wdata_i (y),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = ram_rdata_raw;

`ifndef SYNTH
  // a new transfer never overwrites a stage-1 sample that has not moved on
  a_s1_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s1_v_q) |-> s1_adv)
    else $error("stage 1 overrun");

  // a forward hit at accept arms the forward flag of the sample in stage 1
  a_fwd_needs_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && fwd_hit) |=> s1_v_q && s1_fwd_q)
    else $error("forward flag lost");

  // output only turns valid from an occupied compute stage
  a_out_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_v_q && !s1_v_q) |=> !out_v_q)
    else $error("output valid without source");
`endif

endmodule
